// ===== src/bdc_pkg.sv =====
// Package with the shared types and constants of the button debounce and click classifier.
`default_nettype none
package bdc_pkg;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_HELD     = 2'd1,
		REG_POLARITY = 2'd2,
		REG_QUERY    = 2'd3
	} reg_idx_t;

	localparam int unsigned APB_AW = 4;
	localparam int unsigned APB_DW = 32;

	localparam logic [15:0] DEBOUNCE_RST = 16'd35;
	localparam logic [15:0] HELD_RST     = 16'd1000;
	localparam logic        POLARITY_RST = 1'b1;
	localparam logic [15:0] QUERY_RST    = 16'd1000;

	// Configuration seen by the datapath.
	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] held_ms;
		logic        active_low;
		logic [15:0] query_ms;
	} cfg_t;

	// One result item, last member in the lowest bit.
	typedef struct packed {
		logic released_for;
		logic pressed_for;
		logic long_click;
		logic short_click;
		logic release_event;
		logic press_event;
		logic changed;
		logic pressed;
	} result_t;

endpackage
`default_nettype wire

// ===== src/bdc_apb_regs.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none
module bdc_apb_regs
	import bdc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// Register writes; the low address bits are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= DEBOUNCE_RST;
			cfg_q.held_ms     <= HELD_RST;
			cfg_q.active_low  <= POLARITY_RST;
			cfg_q.query_ms    <= QUERY_RST;
		end else if (wr_en) begin
			case (idx)
				REG_DEBOUNCE: cfg_q.debounce_ms <= pwdata[15:0];
				REG_HELD:     cfg_q.held_ms     <= pwdata[15:0];
				REG_POLARITY: cfg_q.active_low  <= pwdata[0];
				REG_QUERY:    cfg_q.query_ms    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read-back of the addressed register.
	always_comb begin
		case (idx)
			REG_DEBOUNCE: prdata = {16'd0, cfg_q.debounce_ms};
			REG_HELD:     prdata = {16'd0, cfg_q.held_ms};
			REG_POLARITY: prdata = {31'd0, cfg_q.active_low};
			REG_QUERY:    prdata = {16'd0, cfg_q.query_ms};
			default:      prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/bdc_core.sv =====
// Input register, debounce state, click classification and result register.
`default_nettype none
module bdc_core
	import bdc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        in_raw,
	input  wire logic [31:0] in_now,
	output logic             out_valid,
	input  wire logic        out_ready,
	output result_t          out_res
);

	logic        valid_s1;
	logic        raw_s1;
	logic [31:0] now_s1;
	logic        valid_s2;
	result_t     res_s2;

	logic        level_q;
	logic [31:0] last_q;
	logic        held_q;

	logic        advance;
	logic        level;
	logic [31:0] elapsed;
	logic        open;
	logic        chg;
	logic        lvl_new;
	logic        held_new;
	logic        rel;
	logic        since_ok;
	result_t     res;

	// The sample stage moves on when the result register is free or being taken.
	assign advance   = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready  = ~valid_s1 | advance;
	assign out_valid = valid_s2;
	assign out_res   = res_s2;

	// Debounce decision and click classification for the sample in stage one.
	always_comb begin
		level    = raw_s1 ^ cfg.active_low;
		elapsed  = now_s1 - last_q;
		open     = elapsed >= {16'd0, cfg.debounce_ms};
		chg      = open & (level != level_q);
		lvl_new  = open ? level : level_q;
		held_new = chg ? (elapsed >= {16'd0, cfg.held_ms}) : held_q;
		rel      = chg & ~lvl_new;
		// After a change the time since it is zero.
		since_ok = chg ? (cfg.query_ms == 16'd0) : (elapsed >= {16'd0, cfg.query_ms});

		res.pressed       = lvl_new;
		res.changed       = chg;
		res.press_event   = chg & lvl_new;
		res.release_event = rel;
		res.short_click   = rel & ~held_new;
		res.long_click    = rel & held_new;
		res.pressed_for   = lvl_new & since_ok;
		res.released_for  = ~lvl_new & since_ok;
	end

	// Pipeline control and debounce state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			level_q  <= 1'b0;
			last_q   <= '0;
			held_q   <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
			if (advance) begin
				level_q <= lvl_new;
				held_q  <= rel ? 1'b0 : held_new;
				if (chg) begin
					last_q <= now_s1;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			raw_s1 <= in_raw;
			now_s1 <= in_now;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

endmodule
`default_nettype wire

// ===== src/button_debounce_click_classifier.sv =====
// Top level of the button debounce and click classifier.
//
//  channel   | direction | contents
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | one pin sample: raw level and ms timestamp
//  m_axis    | out       | one result item per sample: state and events
//  apb       | in/out    | debounce, held, polarity and query registers
//
// An item enters the sample register, is classified against the stored state
// and lands in the result register; one item per cycle is sustained while the
// result register is not stalled.
// Reset sets the state to released with the last change at time zero.
// A stalled result register holds the sample stage; one more item is taken.
`default_nettype none
module button_debounce_click_classifier
	import bdc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [39:0]       s_tdata,  // [0] raw_level, [32:1] now_ms, [39:33] zero
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// [0] pressed, [1] changed, [2] press_event, [3] release_event,
	// [4] short_click, [5] long_click, [6] pressed_for, [7] released_for
	output logic      [7:0]        m_tdata,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	cfg_t    cfg;
	result_t res;

	bdc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bdc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_raw    (s_tdata[0]),
		.in_now    (s_tdata[32:1]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = res;

`ifndef SYNTH
	// A change is exactly one press or one release.
	a_change_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.changed == (res.press_event ^ res.release_event)))
		else $error("changed does not match press and release events");

	// A click comes only with a release and is either short or long.
	a_click: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (res.short_click || res.long_click)) |->
		(res.release_event && (res.short_click != res.long_click)))
		else $error("click without release or of both kinds");

	// The duration flags follow the debounced level.
	a_dur: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((!res.pressed_for || res.pressed) && (!res.released_for || !res.pressed)))
		else $error("duration flag disagrees with debounced level");

	// A press event shows the pressed state, a release the released state.
	a_event_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((!res.press_event || res.pressed) && (!res.release_event || !res.pressed)))
		else $error("event disagrees with debounced level");
`endif

endmodule
`default_nettype wire
